FILE: hdl/generational_handle_table_top_assert.svh
// Assertion macros for the generational handle table.
// Included by generational_handle_table_top; depends on nothing else.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define GHT_ASSERT_SAME(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define GHT_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

FILE: hdl/ght_pkg.sv
// Shared types and constants for the generational handle table.
// No dependencies; every other file of the block but the assert header uses it.
`default_nettype none

package ght_pkg;

   localparam int unsigned SLOTS_DEFAULT = 256;

   localparam int unsigned FUNC_W      = 2;
   localparam int unsigned PAYLOAD_W   = 32;
   localparam int unsigned KEY_INDEX_W = 8;
   localparam int unsigned GEN_W       = 32;
   localparam int unsigned STATUS_W    = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic clear;    // write one entry of the clearing pass
      logic capture;  // latch the request word
      logic slot;     // select the slot and read its entry
      logic commit;   // update tables and load the result word
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;  // clearing pass is at its last entry
      logic out_free;    // result register can take a word this cycle
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: hdl/ght_req_if.sv
// Request channel of the generational handle table.
// Depends on ght_pkg for field widths.
`default_nettype none

interface ght_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ght_pkg::FUNC_W-1:0]           func;
   logic [ght_pkg::PAYLOAD_W-1:0]        payload;
   logic [ght_pkg::KEY_INDEX_W-1:0]      key_index;
   logic [ght_pkg::GEN_W-1:0]            key_generation;

   modport source (output valid, func, payload, key_index, key_generation, input ready);
   modport sink   (input valid, func, payload, key_index, key_generation, output ready);
endinterface

`default_nettype wire

FILE: hdl/ght_rsp_if.sv
// Result channel of the generational handle table.
// Depends on ght_pkg for field widths.
`default_nettype none

interface ght_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ght_pkg::STATUS_W-1:0]         status;
   logic [ght_pkg::KEY_INDEX_W-1:0]      out_index;
   logic [ght_pkg::GEN_W-1:0]            out_generation;
   logic [ght_pkg::PAYLOAD_W-1:0]        out_payload;

   modport source (output valid, status, out_index, out_generation, out_payload, input ready);
   modport sink   (input valid, status, out_index, out_generation, out_payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/generational_handle_table_top.sv
// Top level of the generational handle table: controller plus datapath.
// Depends on ght_pkg, ght_req_if, ght_rsp_if, ght_ctrl, ght_datapath and the assert header.
//
//   channel   direction  word contents
//   req_chan  in         func, payload, key_index, key_generation
//   rsp_chan  out        status, out_index, out_generation, out_payload
//
// Each request passes accept (free stack top already read), slot entry read,
// then table update and result load; the registered reads of the stack and
// the slot memories call for these separate steps.
// After reset a clearing pass over every entry zeroes generations and live
// bits and refills the free stack; no request is taken during it.
// A stalled result holds the update step; no further request is taken meanwhile.
`default_nettype none

`include "generational_handle_table_top_assert.svh"

module generational_handle_table_top #(
   parameter int unsigned SLOTS = ght_pkg::SLOTS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ght_req_if.sink    req_chan,
   ght_rsp_if.source  rsp_chan
);

   ght_pkg::ctl_cmd_type cmd;
   ght_pkg::dp_sts_type  sts;
   logic                 req_ready;

   // sequence clear, accept, slot read and update
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the tables and the result register
   ght_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_chan.func),
      .req_payload        (req_chan.payload),
      .req_key_index      (req_chan.key_index),
      .req_key_generation (req_chan.key_generation),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_status         (rsp_chan.status),
      .rsp_out_index      (rsp_chan.out_index),
      .rsp_out_generation (rsp_chan.out_generation),
      .rsp_out_payload    (rsp_chan.out_payload)
   );

   assign req_chan.ready = req_ready;

   // one request in flight: no accept in the cycle after an accept
   `GHT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_ready, !req_ready, "request accepted while another is in flight")
   // never overwrite a result word that is still waiting
   `GHT_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.commit, sts.out_free, "result register overwritten while pending")
   // a new result word appears only after an update step
   `GHT_ASSERT_SAME(a_rsp_from_commit, clock, reset, $rose(rsp_chan.valid), $past(cmd.commit), "result word without update step")
   // no request taken during the clearing pass
   `GHT_ASSERT_SAME(a_no_accept_clear, clock, reset, cmd.clear, !req_ready, "request accepted during clearing pass")

endmodule

`default_nettype wire

FILE: hdl/ght_ctrl.sv
// Sequencing state machine of the generational handle table.
// Depends on ght_pkg for the command and status structs.
`default_nettype none

module ght_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ght_pkg::dp_sts_type sts,
   output ght_pkg::ctl_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SLOT  = 4'b0100,
      ST_EXEC  = 4'b1000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SLOT;
            end
         end
         ST_SLOT: begin
            cmd.slot = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // hold until the result register is free
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ght_datapath.sv
// Datapath of the generational handle table: slot memories, free stack, result register.
// Depends on ght_pkg; sequenced by ght_ctrl.
`default_nettype none

module ght_datapath #(
   parameter int unsigned SLOTS = ght_pkg::SLOTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ght_pkg::ctl_cmd_type                cmd,
   output ght_pkg::dp_sts_type                      sts,
   input  wire logic [ght_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [ght_pkg::PAYLOAD_W-1:0]       req_payload,
   input  wire logic [ght_pkg::KEY_INDEX_W-1:0]     req_key_index,
   input  wire logic [ght_pkg::GEN_W-1:0]           req_key_generation,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ght_pkg::STATUS_W-1:0]             rsp_status,
   output logic [ght_pkg::KEY_INDEX_W-1:0]          rsp_out_index,
   output logic [ght_pkg::GEN_W-1:0]                rsp_out_generation,
   output logic [ght_pkg::PAYLOAD_W-1:0]            rsp_out_payload
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);
   localparam int unsigned GEN_W = ght_pkg::GEN_W;
   localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);

   // request word
   logic [ght_pkg::FUNC_W-1:0]      func_ff;
   logic [ght_pkg::PAYLOAD_W-1:0]   pay_ff;
   logic [ght_pkg::KEY_INDEX_W-1:0] kidx_ff;
   logic [GEN_W-1:0]                kgen_ff;

   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ght_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ght_pkg::KEY_INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [GEN_W-1:0]                 rsp_gen_ff, rsp_gen_in;
   logic [ght_pkg::PAYLOAD_W-1:0]    rsp_pay_ff, rsp_pay_in;

   // memories: live bit and generation share one word
   logic [ght_pkg::PAYLOAD_W-1:0] pay_mem   [SLOTS];
   logic [GEN_W:0]                gen_mem   [SLOTS];
   logic [IDX_W-1:0]              stack_mem [SLOTS];

   logic [ght_pkg::PAYLOAD_W-1:0] pay_rd_ff;
   logic [GEN_W:0]                gen_rd_ff;
   logic [IDX_W-1:0]              stack_top_ff;

   logic [CNT_W-1:0] count_dec;
   logic [IDX_W-1:0] key_slot;
   logic             in_range, is_insert, is_lookup, is_remove;
   logic             full, live, key_hit, ins_ok, rem_ok, push_ok;
   logic [GEN_W-1:0] gen, gen_inc;

   logic             gen_we, pay_we, stack_we;
   logic [IDX_W-1:0] gen_wa, stack_wa;
   logic [GEN_W:0]   gen_wd;
   logic [IDX_W-1:0] stack_wd;

   always_comb begin
      count_dec = count_ff - CNT_W'(1);
      key_slot  = IDX_W'(kidx_ff);
      in_range  = 32'(kidx_ff) < 32'(SLOTS);
      is_insert = (func_ff == ght_pkg::FUNC_INSERT);
      is_lookup = (func_ff == ght_pkg::FUNC_LOOKUP);
      is_remove = (func_ff == ght_pkg::FUNC_REMOVE);
      full      = (count_ff == '0);
      live      = gen_rd_ff[GEN_W];
      gen       = gen_rd_ff[GEN_W-1:0];
      gen_inc   = gen + GEN_W'(1);
      key_hit   = in_range && live && (gen == kgen_ff);
      ins_ok    = is_insert && !full;
      rem_ok    = is_remove && key_hit;
      push_ok   = count_ff < SLOT_COUNT;

      // slot of an insert comes off the stack top, else from the key
      slot_in = slot_ff;
      if (cmd.slot) begin
         slot_in = is_insert ? stack_top_ff : key_slot;
      end
   end

   // result word
   always_comb begin
      rsp_status_in = ght_pkg::STATUS_STALE;
      rsp_index_in  = kidx_ff;
      rsp_gen_in    = '0;
      rsp_pay_in    = '0;
      case (func_ff) inside
         ght_pkg::FUNC_INSERT: begin
            if (full) begin
               rsp_status_in = ght_pkg::STATUS_FULL;
               rsp_index_in  = '0;
            end else begin
               rsp_status_in = ght_pkg::STATUS_OK;
               rsp_index_in  = ght_pkg::KEY_INDEX_W'(slot_ff);
               rsp_gen_in    = gen_inc;
            end
         end
         ght_pkg::FUNC_LOOKUP, ght_pkg::FUNC_REMOVE: begin
            if (in_range) begin
               rsp_gen_in = gen;
               if (key_hit) begin
                  rsp_status_in = ght_pkg::STATUS_OK;
                  if (is_lookup) begin
                     rsp_pay_in = pay_rd_ff;
                  end
               end
            end
         end
         default: begin
            rsp_status_in = ght_pkg::STATUS_STALE;
         end
      endcase
   end

   // table writes
   always_comb begin
      gen_we   = cmd.clear || (cmd.commit && (ins_ok || rem_ok));
      gen_wa   = cmd.clear ? clr_ff : slot_ff;
      gen_wd   = '0;
      if (!cmd.clear) begin
         gen_wd = ins_ok ? {1'b1, gen_inc} : {1'b0, gen};
      end
      pay_we   = cmd.commit && ins_ok;
      stack_we = cmd.clear || (cmd.commit && rem_ok && push_ok);
      stack_wa = cmd.clear ? clr_ff : count_ff[IDX_W-1:0];
      stack_wd = cmd.clear ? (LAST_IDX - clr_ff) : slot_ff;

      count_in = count_ff;
      if (cmd.commit && ins_ok) begin
         count_in = count_dec;
      end else if (cmd.commit && rem_ok && push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end

      clr_in = cmd.clear ? (clr_ff + IDX_W'(1)) : clr_ff;

      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      sts.clear_last = (clr_ff == LAST_IDX);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_wa] <= gen_wd;
      end
      if (pay_we) begin
         pay_mem[slot_ff] <= pay_ff;
      end
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      gen_rd_ff    <= gen_mem[slot_in];
      pay_rd_ff    <= pay_mem[slot_in];
      stack_top_ff <= stack_mem[count_dec[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         pay_ff  <= req_payload;
         kidx_ff <= req_key_index;
         kgen_ff <= req_key_generation;
      end
      slot_ff <= slot_in;
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_gen_ff    <= rsp_gen_in;
         rsp_pay_ff    <= rsp_pay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= SLOT_COUNT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_index      = rsp_index_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_out_payload    = rsp_pay_ff;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for generational_handle_table_top: a slot-map shadow predicts every
// result word in order; random traffic exercises insert, lookup and remove under backpressure.
// Depends on ght_pkg, ght_req_if, ght_rsp_if and the block's RTL.

package ght_bench_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_SLOTS = ght_pkg::SLOTS_DEFAULT;

   // func 3 has no operation behind it
   localparam logic [ght_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [ght_pkg::FUNC_W-1:0]      op;
      logic [ght_pkg::PAYLOAD_W-1:0]   payload;
      logic [ght_pkg::KEY_INDEX_W-1:0] key_index;
      logic [ght_pkg::GEN_W-1:0]       key_generation;
   } table_request_type;

   typedef struct packed {
      logic [ght_pkg::STATUS_W-1:0]    status;
      logic [ght_pkg::KEY_INDEX_W-1:0] out_index;
      logic [ght_pkg::GEN_W-1:0]       out_generation;
      logic [ght_pkg::PAYLOAD_W-1:0]   out_payload;
   } table_result_type;

   class handle_table_shadow_type;
      bit [ght_pkg::PAYLOAD_W-1:0] held_word [TABLE_SLOTS];
      bit [ght_pkg::GEN_W-1:0]     slot_gen [TABLE_SLOTS];
      bit                          slot_live [TABLE_SLOTS];
      bit                          slot_written [TABLE_SLOTS];
      int unsigned                 written_slots [$];
      int unsigned                 free_slots [TABLE_SLOTS];
      int unsigned                 free_depth;
      table_result_type            awaited_results [$];
      int unsigned                 mismatches;
      int unsigned                 op_count [4];
      int unsigned                 status_count [4];

      function new();
         for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
            slot_gen[i]     = '0;
            slot_live[i]    = 1'b0;
            slot_written[i] = 1'b0;
            free_slots[i]   = TABLE_SLOTS - 1 - i;
         end
         free_depth = TABLE_SLOTS;
         mismatches = 0;
         for (int i = 0; i < 4; i++) begin
            op_count[i]     = 0;
            status_count[i] = 0;
         end
      endfunction

      // Work out the result word of an accepted request and queue it.
      function void predict_request(table_request_type rq);
         table_result_type want;
         int unsigned      slot;
         want.status         = ght_pkg::STATUS_STALE;
         want.out_index      = rq.key_index;
         want.out_generation = '0;
         want.out_payload    = '0;
         op_count[rq.op]++;
         case (rq.op)
            ght_pkg::FUNC_INSERT: begin
               if (free_depth == 0) begin
                  want.status    = ght_pkg::STATUS_FULL;
                  want.out_index = '0;
               end else begin
                  free_depth--;
                  slot = free_slots[free_depth];
                  held_word[slot] = rq.payload;
                  slot_gen[slot]  = slot_gen[slot] + 1'b1;
                  slot_live[slot] = 1'b1;
                  if (!slot_written[slot]) begin
                     slot_written[slot] = 1'b1;
                     written_slots.push_back(slot);
                  end
                  want.status         = ght_pkg::STATUS_OK;
                  want.out_index      = slot[ght_pkg::KEY_INDEX_W-1:0];
                  want.out_generation = slot_gen[slot];
               end
            end
            ght_pkg::FUNC_LOOKUP, ght_pkg::FUNC_REMOVE: begin
               slot = rq.key_index;
               if (slot < TABLE_SLOTS) begin
                  want.out_generation = slot_gen[slot];
                  if (slot_live[slot] && slot_gen[slot] == rq.key_generation) begin
                     want.status = ght_pkg::STATUS_OK;
                     if (rq.op == ght_pkg::FUNC_LOOKUP) begin
                        want.out_payload = held_word[slot];
                     end else begin
                        slot_live[slot] = 1'b0;
                        if (free_depth < TABLE_SLOTS) begin
                           free_slots[free_depth] = slot;
                           free_depth++;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
         awaited_results.push_back(want);
      endfunction

      function void flag_field(string name, logic [31:0] want, logic [31:0] got);
         $display("%0d ns: %s mismatch, expected 0x%h, actual 0x%h", $time, name,
                  want, got);
         mismatches++;
      endfunction

      // Compare one result word with the oldest prediction.
      function void compare_result(table_result_type got);
         table_result_type want;
         if (awaited_results.size() == 0) begin
            $display("%0d ns: unexpected result word, expected none, actual status %0d index %0d",
                     $time, got.status, got.out_index);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         status_count[got.status]++;
         if (got.status !== want.status)
            flag_field("status", want.status, got.status);
         if (got.out_index !== want.out_index)
            flag_field("out_index", want.out_index, got.out_index);
         if (got.out_generation !== want.out_generation)
            flag_field("out_generation", want.out_generation, got.out_generation);
         if (got.out_payload !== want.out_payload)
            flag_field("out_payload", want.out_payload, got.out_payload);
      endfunction
   endclass

endpackage

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Long receiver hold-off: starts once this many request words went in.
   localparam int unsigned HOLD_OFF_AFTER  = 250;
   localparam int unsigned HOLD_OFF_CYCLES = 150;

   logic clock = 1'b0;
   logic reset;

   ght_req_if req_bus ();
   ght_rsp_if rsp_bus ();

   generational_handle_table_top #(
      .SLOTS(ght_pkg::SLOTS_DEFAULT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   ght_bench_pkg::handle_table_shadow_type shadow = new();

   int unsigned                     accepted_words = 0;
   int                              tx_calm = 0;
   int                              rx_calm = 0;
   ght_bench_pkg::table_result_type rsp_seen;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap length for either side: mostly none or short, sometimes long, and now and
   // then a calm stretch with no gaps at all.
   function automatic int unsigned draw_gap(inout int calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // Offer one request word and hold it until the block takes it.
   task automatic send_word(ght_bench_pkg::table_request_type rq);
      req_bus.valid          <= 1'b1;
      req_bus.func           <= rq.op;
      req_bus.payload        <= rq.payload;
      req_bus.key_index      <= rq.key_index;
      req_bus.key_generation <= rq.key_generation;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      shadow.predict_request(rq);
      accepted_words++;
   endtask

   // Drop valid for a random gap, or keep streaming.
   task automatic rest_sender();
      int unsigned gap;
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_directed(logic [ght_pkg::FUNC_W-1:0] op,
                                logic [ght_pkg::PAYLOAD_W-1:0] word,
                                logic [ght_pkg::KEY_INDEX_W-1:0] idx,
                                logic [ght_pkg::GEN_W-1:0] gen);
      ght_bench_pkg::table_request_type rq;
      rq.op             = op;
      rq.payload        = word;
      rq.key_index      = idx;
      rq.key_generation = gen;
      send_word(rq);
      rest_sender();
   endtask

   // Pause the sender until every predicted result word has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (shadow.awaited_results.size() != 0) @(posedge clock);
   endtask

   // Build a random request. Keys only name slots that were written at least once, so
   // the payload store is never read before it holds data. Most keys carry the slot's
   // current generation; the rest are off by one, random, or use the unused opcode.
   function automatic ght_bench_pkg::table_request_type random_request(
         int unsigned insert_pct, int unsigned remove_pct);
      ght_bench_pkg::table_request_type rq;
      int unsigned                      roll;
      int unsigned                      flavor;
      int unsigned                      slot;
      rq.op             = ght_pkg::FUNC_INSERT;
      rq.payload        = $urandom;
      rq.key_index      = $urandom;
      rq.key_generation = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct || shadow.written_slots.size() == 0) return rq;
      rq.op = (roll < insert_pct + remove_pct) ? ght_pkg::FUNC_REMOVE : ght_pkg::FUNC_LOOKUP;
      // prefer live slots so that well-formed keys mostly hit
      slot = shadow.written_slots[$urandom_range(0, shadow.written_slots.size() - 1)];
      for (int tries = 0; tries < 8 && !shadow.slot_live[slot]; tries++)
         slot = shadow.written_slots[$urandom_range(0, shadow.written_slots.size() - 1)];
      rq.key_index = slot[ght_pkg::KEY_INDEX_W-1:0];
      flavor = $urandom_range(0, 9);
      if (flavor <= 6)
         rq.key_generation = shadow.slot_gen[slot];
      else if (flavor == 7)
         rq.key_generation = $urandom_range(0, 1) ? shadow.slot_gen[slot] + 1'b1
                                                  : shadow.slot_gen[slot] - 1'b1;
      else if (flavor == 9)
         rq.op = ght_bench_pkg::FUNC_UNUSED;
      return rq;
   endfunction

   task automatic run_phase(int unsigned count, int unsigned insert_pct,
                            int unsigned remove_pct);
      repeat (count) begin
         send_word(random_request(insert_pct, remove_pct));
         rest_sender();
      end
      wait_drained();
   endtask

   // Result side: hold ready off in random gaps, plus one long hold-off while the
   // sender keeps offering words so the block backs up and stalls its input.
   initial begin
      bit held_off;
      int unsigned stall;
      held_off = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && accepted_words >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            stall = draw_gap(rx_calm);
            if (stall == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   // Check every result word taken at a clock edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen.status         = rsp_bus.status;
         rsp_seen.out_index      = rsp_bus.out_index;
         rsp_seen.out_generation = rsp_bus.out_generation;
         rsp_seen.out_payload    = rsp_bus.out_payload;
         shadow.compare_result(rsp_seen);
      end
   end

   // Hard stop: covers the clearing pass and the slowest legal run many times over.
   initial begin
      #6ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.func           = ght_pkg::FUNC_INSERT;
      req_bus.payload        = '0;
      req_bus.key_index      = '0;
      req_bus.key_generation = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: payload extremes, each operation, stale and free-slot keys,
      // LIFO reuse with a bumped generation, and the unused opcode.
      send_directed(ght_pkg::FUNC_INSERT, 32'h0000_0000, 8'd0, 32'd0);
      send_directed(ght_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 8'd0, 32'd0);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h1234_5678, 8'd0, 32'd1);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'd1, 32'd1);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'd1, 32'd2);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'd1, 32'hFFFF_FFFF);
      send_directed(ght_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 8'd0, 32'd1);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'd0, 32'd1);
      send_directed(ght_pkg::FUNC_REMOVE, 32'h0000_0000, 8'd0, 32'd1);
      send_directed(ght_pkg::FUNC_INSERT, 32'hA5A5_A5A5, 8'hFF, 32'hFFFF_FFFF);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'd0, 32'd1);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'd0, 32'd2);
      send_directed(ght_bench_pkg::FUNC_UNUSED, 32'hFFFF_FFFF, 8'd1, 32'd1);
      send_directed(ght_pkg::FUNC_REMOVE, 32'h0000_0000, 8'd1, 32'd1);
      send_directed(ght_pkg::FUNC_REMOVE, 32'h0000_0000, 8'd0, 32'd2);
      send_directed(ght_pkg::FUNC_INSERT, 32'h5A5A_5A5A, 8'd0, 32'd0);
      send_directed(ght_pkg::FUNC_INSERT, 32'h8000_0001, 8'd0, 32'd0);
      send_directed(ght_pkg::FUNC_LOOKUP, 32'h0000_0000, 8'd1, 32'd2);
      wait_drained();

      // Random: mixed traffic, a fill past full, a drain, then mixed again.
      run_phase(450, 40, 25);
      run_phase(550, 75, 10);
      run_phase(400, 15, 60);
      run_phase(400, 35, 30);

      // Settle: let any stray word show up before the verdict.
      repeat (20) @(posedge clock);

      $display("Requests: %0d inserts, %0d lookups, %0d removes, %0d unused-opcode words",
               shadow.op_count[ght_pkg::FUNC_INSERT], shadow.op_count[ght_pkg::FUNC_LOOKUP],
               shadow.op_count[ght_pkg::FUNC_REMOVE],
               shadow.op_count[ght_bench_pkg::FUNC_UNUSED]);
      $display("Results: %0d ok, %0d table full, %0d stale or free; %0d mismatches",
               shadow.status_count[ght_pkg::STATUS_OK],
               shadow.status_count[ght_pkg::STATUS_FULL],
               shadow.status_count[ght_pkg::STATUS_STALE], shadow.mismatches);
      if (shadow.mismatches == 0 && shadow.awaited_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ght_pkg.sv
hdl/ght_req_if.sv
hdl/ght_rsp_if.sv
hdl/ght_ctrl.sv
hdl/ght_datapath.sv
hdl/generational_handle_table_top.sv
bench/testbench.sv
